### rtl/arl_pkg.sv
// Package for the address region lookup unit: field widths, operation codes, sequencer states.
package arl_pkg;

	localparam int START_W   = 64;
	localparam int SIZE_W    = 32;
	localparam int ADDR_W    = 64;
	localparam int SLOT_W    = 8;
	localparam int MATCH_W   = 8;
	localparam int ENTRIES_W = 9;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam int ST_W = 2;
	localparam logic [ST_W-1:0] S_IDLE   = 2'd0;
	localparam logic [ST_W-1:0] S_SEARCH = 2'd1;
	localparam logic [ST_W-1:0] S_CHECK  = 2'd2;
	localparam logic [ST_W-1:0] S_DONE   = 2'd3;

endpackage

### rtl/address_region_lookup_unit.sv
// Address region lookup unit: region table in memory with a binary search sequencer.
//
// Use:
//   The input channel (in_valid/in_ready) carries one item per operation. A write item
//   (operation = 0) stores entry_start and entry_size at slot entry_index, reduced modulo
//   TABLE_DEPTH, in the accepting cycle and gives no result. A lookup item (operation = 1)
//   searches the first entries_in_use entries, which software loads in ascending order of
//   start, and gives one result item (found, match_index) on out_valid/out_ready.
//   The user must write entries_in_use through cfg_we/cfg_wdata only while the unit
//   is idle; the unit itself does not enforce this. Values above TABLE_DEPTH count
//   as TABLE_DEPTH.
// Sequence:
//   A lookup makes floor(log2(entries_in_use + 1)) to ceil(log2(entries_in_use + 1))
//   search reads, plus one read for the bound check when some start lies at or below
//   the address, then hands the result to the output register. The single read port
//   of the region memories serves every read; the unit works on one item at a time.
// Reset:
//   arst_n clears the sequencer state, out_valid and entries_in_use. The region
//   memories are not cleared; a lookup must only reach entries written since reset.
// Stall:
//   A result waits in the output register while out_ready is low. The unit still takes
//   the next item and runs its search; it holds that result until the register frees up.
module address_region_lookup_unit
	import arl_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [ENTRIES_W-1:0]   cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   operation,
	input  logic [SLOT_W-1:0]      entry_index,
	input  logic [START_W-1:0]     entry_start,
	input  logic [SIZE_W-1:0]      entry_size,
	input  logic [ADDR_W-1:0]      query_address,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   found,
	output logic [MATCH_W-1:0]     match_index
);

	localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CW    = (CNT_W > ENTRIES_W) ? CNT_W : ENTRIES_W;

	// Slot reduction: restoring compare-subtract over the eight bits of the index.
	function automatic logic [AW-1:0] slot_of(input logic [SLOT_W-1:0] idx);
		logic [31:0] rem;
		rem = 32'(idx);
		for (int k = SLOT_W - 1; k >= 0; k--) begin
			if (rem >= (32'(TABLE_DEPTH) << k)) begin
				rem = rem - (32'(TABLE_DEPTH) << k);
			end
		end
		return rem[AW-1:0];
	endfunction

	// Region memories, one read port with registered data.
	logic [START_W-1:0] start_mem [TABLE_DEPTH];
	logic [SIZE_W-1:0]  size_mem  [TABLE_DEPTH];
	logic [START_W-1:0] rd_start;
	logic [SIZE_W-1:0]  rd_size;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;

	logic [ENTRIES_W-1:0] entries_in_use_q;
	logic [ST_W-1:0]      state_q, state_d;
	logic [CNT_W-1:0]     lo_q, lo_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [ADDR_W-1:0]    addr_q;
	logic                 hit_q, hit_d;
	logic                 out_valid_q;
	logic                 found_q;
	logic [MATCH_W-1:0]   match_q;

	logic [CW-1:0]        cfg_ext;
	logic [CNT_W-1:0]     n_clamped;
	logic [CNT_W-1:0]     half;
	logic [CNT_W-1:0]     mid;
	logic [CNT_W-1:0]     next_mid;
	logic [CNT_W-1:0]     cand;
	logic [ADDR_W-1:0]    offset;
	logic                 start_le;
	logic                 out_free;
	logic                 accept;

	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign match_index = match_q;
	assign out_free    = !out_valid_q || out_ready;

	assign cfg_ext   = CW'(entries_in_use_q);
	assign n_clamped = (cfg_ext > CW'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(cfg_ext);

	assign half     = count_q >> 1;
	assign mid      = lo_q + half;
	assign cand     = lo_q - CNT_W'(1);
	assign start_le = (rd_start <= addr_q);
	assign offset   = addr_q - rd_start;

	assign wr_en   = accept && (operation == OP_WRITE);
	assign wr_addr = slot_of(entry_index);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_mem[wr_addr] <= entry_start;
			size_mem[wr_addr]  <= entry_size;
		end
		if (rd_en) begin
			rd_start <= start_mem[rd_addr];
			rd_size  <= size_mem[rd_addr];
		end
	end

	// Search sequencer: each S_SEARCH cycle consumes one probe and may issue a read.
	always_comb begin
		state_d  = state_q;
		lo_d     = lo_q;
		count_d  = count_q;
		hit_d    = hit_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		next_mid = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && operation == OP_LOOKUP) begin
					lo_d    = '0;
					count_d = n_clamped;
					if (n_clamped != '0) begin
						next_mid = n_clamped >> 1;
						rd_en    = 1'b1;
						rd_addr  = next_mid[AW-1:0];
						state_d  = S_SEARCH;
					end else begin
						// empty table: miss without a read
						hit_d   = 1'b0;
						state_d = S_DONE;
					end
				end
			end
			S_SEARCH: begin
				if (start_le) begin
					lo_d    = mid + CNT_W'(1);
					count_d = count_q - half - CNT_W'(1);
				end else begin
					count_d = half;
				end
				if (count_d != '0) begin
					next_mid = lo_d + (count_d >> 1);
					rd_en    = 1'b1;
					rd_addr  = next_mid[AW-1:0];
				end else if (lo_d == '0) begin
					// every probed start lies above the address
					hit_d   = 1'b0;
					state_d = S_DONE;
				end else begin
					next_mid = lo_d - CNT_W'(1);
					rd_en    = 1'b1;
					rd_addr  = next_mid[AW-1:0];
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				// zero size means unbounded; the difference form cannot wrap
				hit_d   = (rd_size == '0) || (offset < ADDR_W'(rd_size));
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			entries_in_use_q <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				entries_in_use_q <= cfg_wdata;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers: no reset needed.
	always_ff @(posedge clk) begin
		lo_q    <= lo_d;
		count_q <= count_d;
		hit_q   <= hit_d;
		if (accept) begin
			addr_q <= query_address;
		end
		if (state_q == S_DONE && out_free) begin
			found_q <= hit_q;
			match_q <= hit_q ? MATCH_W'(cand) : '0;
		end
	end

	// A miss reports index zero.
	a_miss_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_index == '0)
		else $error("miss result carries a nonzero index");

	// The search window never runs past the table.
	a_window_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> (CNT_W + 1)'(lo_q) + (CNT_W + 1)'(count_q)
			<= (CNT_W + 1)'(TABLE_DEPTH))
		else $error("search window exceeds table depth");

	// A finished lookup waits while the pending result is not taken.
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_valid && !out_ready |=> state_q == S_DONE)
		else $error("result register overwritten while stalled");

	// Entering the search always issues a memory read.
	a_probe_issued: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_SEARCH && state_d == S_SEARCH |-> rd_en)
		else $error("search entered without a memory read");

endmodule

### test/address_region_lookup_unit_tb.sv
// Self-checking testbench for the address region lookup unit.
`timescale 1ns / 100ps

module address_region_lookup_unit_tb;
	import arl_pkg::*;

	localparam int TABLE_DEPTH     = 256;
	localparam int SETTLE_CYCLES   = 16;    // covers the longest lookup plus output handoff
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int ITEM_TARGET     = 1900;

	// One lookup outcome: hit flag plus the index of the containing region.
	typedef struct packed {
		logic               found;
		logic [MATCH_W-1:0] idx;
	} region_hit_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_we        = 1'b0;
	logic [ENTRIES_W-1:0] cfg_wdata     = '0;
	logic                 in_valid      = 1'b0;
	logic                 in_ready;
	logic                 operation     = OP_WRITE;
	logic [SLOT_W-1:0]    entry_index   = '0;
	logic [START_W-1:0]   entry_start   = '0;
	logic [SIZE_W-1:0]    entry_size    = '0;
	logic [ADDR_W-1:0]    query_address = '0;
	logic                 out_valid;
	logic                 out_ready     = 1'b0;
	logic                 found;
	logic [MATCH_W-1:0]   match_index;

	// Shadow copy of the region table, updated as items are accepted, and of the entry count.
	logic [START_W-1:0]   start_tab [TABLE_DEPTH];
	logic [SIZE_W-1:0]    size_tab  [TABLE_DEPTH];
	logic [ENTRIES_W-1:0] table_count = '0;

	region_hit_t pending_hits [$];

	int mismatches     = 0;
	int items_sent     = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_asked     = 0;
	int hold_seen      = 0;
	int hold_left      = 0;

	address_region_lookup_unit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.entry_index  (entry_index),
		.entry_start  (entry_start),
		.entry_size   (entry_size),
		.query_address(query_address),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.match_index  (match_index)
	);

	// 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Abort a hung run; a correct run finishes in a small fraction of this.
	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [SIZE_W-1:0] rand_size();
		case ($urandom_range(5))
			0: return '0;                       // unbounded region
			1: return '1;
			2: return $urandom;
			3: return SIZE_W'($urandom_range(1, 64));
			default: return $urandom >> $urandom_range(31);
		endcase
	endfunction

	// Search the shadow table the way the unit does: find the last start at or below
	// the address within the window, then check the bound as address - start >= size.
	function automatic region_hit_t search_regions(logic [ADDR_W-1:0] addr);
		int unsigned lo, span, half, mid, n;
		region_hit_t hit;
		n    = (table_count > TABLE_DEPTH) ? TABLE_DEPTH : table_count;
		lo   = 0;
		span = n;
		hit  = '0;
		while (span > 0) begin
			half = span / 2;
			mid  = lo + half;
			if (start_tab[mid] <= addr) begin
				lo   = mid + 1;
				span = span - half - 1;
			end else begin
				span = half;
			end
		end
		if (lo != 0) begin
			hit.found = 1'b1;
			hit.idx   = MATCH_W'(lo - 1);
			if (size_tab[lo-1] != 0 && (addr - start_tab[lo-1]) >= {32'd0, size_tab[lo-1]})
				hit = '0;
		end
		return hit;
	endfunction

	// Aim half the picks at region edges: start, one below, last byte, one past the end.
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned n, k;
		logic [63:0] base, sz;
		n = (table_count > TABLE_DEPTH) ? TABLE_DEPTH : table_count;
		if (n == 0)
			return rand64();
		k    = $urandom_range(n - 1);
		base = start_tab[k];
		sz   = {32'd0, size_tab[k]};
		case ($urandom_range(7))
			0: return rand64();
			1: return base;
			2: return base - 1;
			3: return base + sz;
			4: return base + sz - 1;
			5: return (sz != 0) ? base + rand64() % sz : base + (rand64() >> $urandom_range(63));
			default: return base + ($urandom & 32'hFFFF);
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
		mismatches++;
		$display("t=%0t %s: expected %0h, got %0h", $time, what, want, got);
	endtask

	// Drive one item from a falling edge, hold it until accepted, then record the prediction.
	task automatic send_item(logic op, logic [SLOT_W-1:0] slot, logic [START_W-1:0] start,
	                         logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		entry_index   <= slot;
		entry_start   <= start;
		entry_size    <= size;
		query_address <= addr;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (op == OP_LOOKUP) begin
			pending_hits.push_back(search_regions(addr));
		end else begin
			start_tab[slot % TABLE_DEPTH] = start;
			size_tab[slot % TABLE_DEPTH]  = size;
		end
		@(negedge clk);
	endtask

	// Unused fields get random values so their bits toggle too.
	task automatic write_region(logic [SLOT_W-1:0] slot, logic [START_W-1:0] start,
	                            logic [SIZE_W-1:0] size);
		send_item(OP_WRITE, slot, start, size, rand64());
	endtask

	task automatic lookup(logic [ADDR_W-1:0] addr);
		send_item(OP_LOOKUP, SLOT_W'($urandom), rand64(), rand_size(), addr);
	endtask

	// Hold the input idle until every expected result is back and the unit has settled.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_hits.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write entries_in_use; only done with the unit idle.
	task automatic set_entries(int unsigned n);
		drain();
		cfg_we      <= 1'b1;
		cfg_wdata   <= ENTRIES_W'(n);
		table_count  = ENTRIES_W'(n);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_idle_phase(int phase);
		case (phase % 4)
			0: begin
				send_idle_pct  <= 0;
				recv_stall_pct <= 0;
			end
			1: begin
				send_idle_pct  <= 84;
				recv_stall_pct <= 0;
			end
			2: begin
				send_idle_pct  <= 0;
				recv_stall_pct <= 84;
			end
			default: begin
				send_idle_pct  <= 11;
				recv_stall_pct <= 11;
			end
		endcase
	endtask

	// Fill the first slots; ascending tables get random gaps sized so starts never wrap.
	task automatic load_regions(int unsigned slots, bit ascending);
		logic [63:0] cursor, step_max, gap;
		step_max = (64'hFFFF_FFFF_FFFF_FFFF / (slots + 1)) >> $urandom_range(40);
		cursor   = rand64() % (step_max + 1);
		for (int i = 0; i < slots; i++) begin
			gap = ($urandom_range(15) == 0) ? 64'd0 : rand64() % (step_max + 1);
			write_region(SLOT_W'(i), ascending ? cursor : rand64(), rand_size());
			cursor = cursor + gap;
		end
	endtask

	// Receiver: random stalls, or a long hold-off counted here when one is asked for.
	always @(negedge clk) begin
		if (hold_asked != hold_seen) begin
			hold_seen <= hold_asked;
			hold_left <= HOLD_OFF_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin : check_results
		region_hit_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_hits.size() == 0) begin
				report_mismatch("result with nothing pending", 64'd0,
				                64'({found, match_index}));
			end else begin
				want = pending_hits.pop_front();
				if (found !== want.found)
					report_mismatch("found", 64'(want.found), 64'(found));
				if (match_index !== want.idx)
					report_mismatch("match_index", 64'(want.idx), 64'(match_index));
			end
		end
	end

	// After reset the count is zero, so every lookup misses without touching the table.
	task automatic test_empty_table();
		lookup('0);
		lookup('1);
		lookup(rand64());
	endtask

	// Small hand-built table: below the first start, bounded and unbounded regions,
	// one past the end and sizes at both extremes.
	task automatic test_directed_regions();
		set_entries(0);
		lookup(64'h10);
		write_region(8'd0, 64'h10, 32'h10);
		write_region(8'd1, 64'h100, 32'h0);
		write_region(8'd2, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
		write_region(8'd3, 64'hFFFF_FFFF_FFFF_FFF0, 32'h1);
		write_region(8'd255, '1, 32'h0);
		set_entries(4);
		lookup(64'h0);
		lookup(64'h10);
		lookup(64'h1F);
		lookup(64'h20);
		lookup(64'h100);
		lookup(64'h7FFF_FFFF_FFFF_FFFF);
		lookup(64'h8000_0000_FFFF_FFFE);
		lookup(64'h8000_0000_FFFF_FFFF);
		lookup(64'hFFFF_FFFF_FFFF_FFF0);
		lookup('1);
		set_entries(1);
		lookup(64'h15);
		lookup(64'h200);
	endtask

	// Full sorted table, then counts past the table depth, which clamp to it.
	task automatic test_full_table();
		load_regions(TABLE_DEPTH, 1'b1);
		set_entries(TABLE_DEPTH);
		lookup('1);
		lookup(start_tab[TABLE_DEPTH-1]);
		repeat (150) lookup(pick_address());
		set_entries(511);
		repeat (30) lookup(pick_address());
		set_entries(300);
		repeat (30) lookup(pick_address());
	endtask

	// Hold off the receiver while items keep coming so the input stalls and wait until
	// everything is back, then send more lookups from a mostly idle sender without a hold-off.
	task automatic test_backpressure();
		set_entries(TABLE_DEPTH);
		apply_idle_phase(0);
		hold_asked <= hold_asked + 1;
		repeat (30) lookup(pick_address());
		drain();
		apply_idle_phase(1);
		repeat (20) lookup(pick_address());
		drain();
	endtask

	// Unsorted content: the search is still fully defined.
	task automatic test_unsorted_table();
		apply_idle_phase(3);
		load_regions(TABLE_DEPTH, 1'b0);
		set_entries(TABLE_DEPTH);
		repeat (50) lookup(pick_address());
		set_entries(100);
		repeat (30) lookup(pick_address());
	endtask

	// Random rounds: pick a count, reload that many sorted entries up to the depth (at times
	// unsorted), then look up with a few stray writes mixed in. Every slot is written by now.
	task automatic test_random_tables();
		int unsigned n, round;
		round = 0;
		while (items_sent < ITEM_TARGET) begin
			apply_idle_phase(round);
			case ($urandom_range(15))
				0: n = 0;
				1, 2: n = TABLE_DEPTH;
				3: n = $urandom_range(TABLE_DEPTH + 1, 511);
				default: n = $urandom_range(1, 32);
			endcase
			set_entries(n);
			load_regions((n > TABLE_DEPTH) ? TABLE_DEPTH : n, $urandom_range(7) != 0);
			repeat ($urandom_range(40, 80)) begin
				if ($urandom_range(7) == 0)
					write_region(SLOT_W'($urandom), rand64(), rand_size());
				else
					lookup(pick_address());
			end
			round++;
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_table();
		test_directed_regions();
		test_full_table();
		test_backpressure();
		test_unsorted_table();
		test_random_tables();
		drain();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
rtl/arl_pkg.sv
rtl/address_region_lookup_unit.sv
test/address_region_lookup_unit_tb.sv
